@@ hdl/tiws_pkg.sv @@
// Shared types and constants for the tile intensity window and stretch mapper.
`timescale 1ns / 1ps
`default_nettype none
package tiws_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned NumW     = 2 * PixW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned DivSteps = PixW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [PixW-1:0] PixMax = {PixW{1'b1}};
  localparam logic [PixW-1:0] PixMin = '0;

  localparam logic CmdMeasure = 1'b0;
  localparam logic CmdMap     = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ISO_CUTOFF     = 2'd0,
    REG_STRETCH_ENABLE = 2'd1,
    REG_WINDOW_LOW     = 2'd2,
    REG_WINDOW_HIGH    = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

@@ hdl/tiws_if.sv @@
// Valid/ready channel interfaces for input pixels and mapped pixels.
`timescale 1ns / 1ps
`default_nettype none
interface tiws_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] pixel;
  logic       first_in_tile;

  modport source (output valid, output cmd, output pixel, output first_in_tile, input ready);
  modport sink   (input valid, input cmd, input pixel, input first_in_tile, output ready);
endinterface

interface tiws_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_pixel;

  modport source (output valid, output out_pixel, input ready);
  modport sink   (input valid, input out_pixel, output ready);
endinterface
`default_nettype wire

@@ hdl/tiws_div.sv @@
// Restoring divider, one quotient bit per cycle, with round-half-even result.
`timescale 1ns / 1ps
`default_nettype none
module tiws_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [tiws_pkg::NumW-1:0]         num_i,
  input  logic [tiws_pkg::PixW-1:0]         den_i,
  output tiws_pkg::div_status_t             status_o,
  output logic [tiws_pkg::PixW-1:0]         quo_o
);
  import tiws_pkg::*;

  logic [PixW-1:0]    rem_q, rem_d;
  logic [PixW-1:0]    quo_q, quo_d;
  logic [PixW-1:0]    den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [PixW:0] trial;
  logic [PixW:0] diff;
  logic          fits;
  logic [PixW:0] twice_rem;
  logic          round_up;

  assign trial = {rem_q, quo_q[PixW-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    rem_d = fits ? diff[PixW-1:0] : trial[PixW-1:0];
    quo_d = {quo_q[PixW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[NumW-1:PixW];
      quo_q <= num_i[PixW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // round to nearest, ties to even
  assign twice_rem = {rem_q, 1'b0};
  assign round_up  = (twice_rem > {1'b0, den_q}) ||
                     ((twice_rem == {1'b0, den_q}) && quo_q[0]);
  assign quo_o     = quo_q + PixW'(round_up);

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule
`default_nettype wire

@@ hdl/tile_intensity_window_stretch_top.sv @@
// Timing: a measure word is absorbed in its accept cycle; a saturating map word is
// held in res_q, then in out_data_q; a divided map word passes the divider first.
// Throughput: one measure word per cycle while idle; after a map word no word is taken
// until it loads out_data_q. The divider runs 8 steps on a shared subtract/compare.
// Reset: async active low; control and config registers default, tile min 255, max 0.
`timescale 1ns / 1ps
`default_nettype none
module tile_intensity_window_stretch_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tiws_in_if.sink                           in_i,
  tiws_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [tiws_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tiws_pkg::CfgDataW-1:0]     cfg_data_i
);
  import tiws_pkg::*;

  logic [PixW-1:0] iso_q;
  logic            stretch_q;
  logic [PixW-1:0] wlo_q;
  logic [PixW-1:0] whi_q;
  logic [PixW-1:0] min_q;
  logic [PixW-1:0] max_q;

  state_e          state_q, state_d;
  logic [PixW-1:0] res_q, res_d;
  logic            out_valid_q;
  logic [PixW-1:0] out_data_q;

  logic            accept;
  logic            out_load;
  logic [PixW-1:0] p_cut;
  logic [PixW-1:0] lo;
  logic [PixW-1:0] den;
  logic [PixW:0]   win_lo_p1;
  logic [PixW:0]   win_hi;
  logic [PixW:0]   win_den;
  logic [PixW:0]   lo_plus_den;
  logic            sat_low;
  logic            sat_high;
  logic [PixW-1:0] d;
  logic [NumW-1:0] num;
  logic            div_start;
  div_status_t     div_status;
  logic [PixW-1:0] div_quo;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  assign out_o.valid     = out_valid_q;
  assign out_o.out_pixel = out_data_q;

  // iso cutoff; a zero cutoff never fires
  assign p_cut = (in_i.pixel < iso_q) ? PixMin : in_i.pixel;

  always_comb begin
    win_lo_p1   = {1'b0, wlo_q} + (PixW + 1)'(1);
    win_hi      = ({1'b0, whi_q} < win_lo_p1) ? win_lo_p1 : {1'b0, whi_q};
    win_den     = win_hi - {1'b0, wlo_q};
    if (stretch_q) begin
      lo  = min_q;
      den = (max_q > min_q) ? (max_q - min_q) : PixW'(1);
    end else begin
      lo  = wlo_q;
      den = win_den[PixW-1:0];
    end
    lo_plus_den = {1'b0, lo} + {1'b0, den};
    sat_low     = p_cut <= lo;
    sat_high    = {1'b0, p_cut} >= lo_plus_den;
    d           = p_cut - lo;
    num         = {d, PixMin} - {PixMin, d};
  end

  assign div_start = accept && (in_i.cmd == CmdMap) && !sat_low && !sat_high;

  tiws_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (num),
    .den_i    (den),
    .status_o (div_status),
    .quo_o    (div_quo)
  );

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.cmd == CmdMap)) begin
          if (sat_low) begin
            res_d   = PixMin;
            state_d = ST_OUT;
          end else if (sat_high) begin
            res_d   = PixMax;
            state_d = ST_OUT;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          res_d   = div_quo;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iso_q     <= PixMin;
      stretch_q <= 1'b0;
      wlo_q     <= PixMin;
      whi_q     <= PixMax;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ISO_CUTOFF:     iso_q     <= cfg_data_i[PixW-1:0];
        REG_STRETCH_ENABLE: stretch_q <= cfg_data_i[0];
        REG_WINDOW_LOW:     wlo_q     <= cfg_data_i[PixW-1:0];
        REG_WINDOW_HIGH:    whi_q     <= cfg_data_i[PixW-1:0];
        default: begin
        end
      endcase
    end
  end

  // tile min/max tracking on measure words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= PixMax;
      max_q <= PixMin;
    end else if (accept && (in_i.cmd == CmdMeasure)) begin
      if (in_i.first_in_tile) begin
        min_q <= p_cut;
        max_q <= p_cut;
      end else begin
        if (p_cut < min_q) begin
          min_q <= p_cut;
        end
        if (p_cut > max_q) begin
          max_q <= p_cut;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ tb/tb_tile_intensity_window_stretch_top.sv @@
// Self-checking bench for the tile grey mapper: directed and random words against a local predictor.
`timescale 1ns / 1ps
module tb_tile_intensity_window_stretch_top;
  import tiws_pkg::*;

  localparam int unsigned LimitCycles  = 400000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned PhaseWords   = 180;
  localparam int unsigned PendDepth    = 16;

  typedef struct packed {
    logic            is_cfg;
    cfg_reg_e        reg_id;
    logic [7:0]      value;
    logic            cmd;
    logic [PixW-1:0] pixel;
    logic            first;
    logic            known;
    logic [PixW-1:0] grey;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  tiws_in_if  in_if ();
  tiws_out_if out_if ();

  tile_intensity_window_stretch_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  logic [PixW-1:0] iso_q, low_q, high_q;
  logic            stretch_q;
  logic [PixW-1:0] tile_lo, tile_hi;
  logic [PixW-1:0] pending_grey [PendDepth];
  logic [$clog2(PendDepth)-1:0] pend_wr = '0;
  logic [$clog2(PendDepth)-1:0] pend_rd = '0;
  int unsigned     pend_cnt = 0;
  logic            word_known;
  logic [PixW-1:0] word_grey;
  int unsigned     fail_cnt = 0;
  int unsigned     cycle_cnt = 0;
  int unsigned     hold_left;
  bit              idle_on;
  bit              stall_req;
  plan_row_t       plan [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // 255*d/den rounded to nearest, ties to even, saturated
  function automatic logic [PixW-1:0] rounded_scale(int d, int den);
    int unsigned num, q, r;
    if (d <= 0) return PixMin;
    if (d >= den) return PixMax;
    num = 255 * d;
    q = num / den;
    r = num % den;
    if (2 * r > den || (2 * r == den && q[0])) q++;
    return q[PixW-1:0];
  endfunction

  function automatic logic [PixW-1:0] cut_level(logic [PixW-1:0] p);
    return (iso_q != 0 && p < iso_q) ? PixMin : p;
  endfunction

  function automatic logic [PixW-1:0] mapped_grey(logic [PixW-1:0] p);
    int lo, hi, span;
    if (stretch_q) begin
      span = int'(tile_hi) - int'(tile_lo);
      if (span < 1) span = 1;
      return rounded_scale(int'(p) - int'(tile_lo), span);
    end
    lo = int'(low_q);
    hi = int'(high_q);
    if (hi < lo + 1) hi = lo + 1;
    return rounded_scale(int'(p) - lo, hi - lo);
  endfunction

  function automatic logic [PixW-1:0] any_pixel();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return PixMin;
    if (r == 1) return PixMax;
    return PixW'($urandom_range(255));
  endfunction

  function automatic plan_row_t item_row(logic cmd, logic [PixW-1:0] pix, logic first,
                                         logic known, logic [PixW-1:0] grey);
    return '{1'b0, REG_ISO_CUTOFF, 8'd0, cmd, pix, first, known, grey};
  endfunction

  function automatic plan_row_t cfg_row(cfg_reg_e idx, logic [7:0] val);
    return '{1'b1, idx, val, CmdMeasure, PixMin, 1'b0, 1'b0, PixMin};
  endfunction

  task automatic send_word(logic cmd, logic [PixW-1:0] pix, logic first,
                           logic known, logic [PixW-1:0] grey);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 36) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.cmd           <= cmd;
    in_if.pixel         <= pix;
    in_if.first_in_tile <= first;
    word_known          <= known;
    word_grey           <= grey;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // drop valid, drain every pending word, then let the divider go quiet
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    word_known  <= 1'b0;
    while (pend_cnt != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [7:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_ISO_CUTOFF:     iso_q = val;
      REG_STRETCH_ENABLE: stretch_q = val[0];
      REG_WINDOW_LOW:     low_q = val;
      REG_WINDOW_HIGH:    high_q = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    logic [PixW-1:0] p, g;
    if (rst_n) begin
      cycle_cnt++;
      if (cycle_cnt > LimitCycles) begin
        $display("tile_intensity_window_stretch_top verification failed");
        $finish;
      end
      if (in_if.valid && in_if.ready) begin
        p = cut_level(in_if.pixel);
        if (in_if.cmd == CmdMeasure) begin
          if (in_if.first_in_tile) begin
            tile_lo = p;
            tile_hi = p;
          end else begin
            if (p < tile_lo) tile_lo = p;
            if (p > tile_hi) tile_hi = p;
          end
        end else begin
          g = mapped_grey(p);
          pending_grey[pend_wr] = word_known ? word_grey : g;
          pend_wr++;
          pend_cnt++;
        end
      end
      if (out_if.valid && out_if.ready) begin
        if (pend_cnt == 0) begin
          $error("out_pixel: expected no word, actual %0d", out_if.out_pixel);
          fail_cnt++;
        end else begin
          g = pending_grey[pend_rd];
          pend_rd++;
          pend_cnt--;
          if (out_if.out_pixel !== g) begin
            $error("out_pixel: expected %0d, actual %0d", g, out_if.out_pixel);
            fail_cnt++;
          end
        end
      end
    end
  end

  // hold off for a long stretch on request, else idle at random while idle_on is set
  initial begin
    out_if.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_req) begin
        stall_req = 1'b0;
        hold_left = HoldCycles - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(idle_on && $urandom_range(99) < 36);
      end
    end
  end

  initial begin
    int unsigned sent, n, m;
    logic        c;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.cmd           = CmdMeasure;
    in_if.pixel         = PixMin;
    in_if.first_in_tile = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = REG_ISO_CUTOFF;
    cfg_data            = '0;
    word_known          = 1'b0;
    word_grey           = PixMin;
    iso_q               = 8'd0;
    stretch_q           = 1'b0;
    low_q               = 8'd0;
    high_q              = 8'd255;
    tile_lo             = PixMax;
    tile_hi             = PixMin;
    idle_on             = 1'b1;
    stall_req           = 1'b0;

    plan.push_back(item_row(CmdMap, 8'd0, 1'b0, 1'b1, 8'd0));
    plan.push_back(item_row(CmdMap, 8'd255, 1'b0, 1'b1, 8'd255));
    plan.push_back(item_row(CmdMap, 8'd128, 1'b1, 1'b1, 8'd128));
    plan.push_back(cfg_row(REG_STRETCH_ENABLE, 8'd1));
    plan.push_back(item_row(CmdMap, 8'd255, 1'b0, 1'b1, 8'd0));
    plan.push_back(item_row(CmdMap, 8'd0, 1'b1, 1'b1, 8'd0));
    plan.push_back(cfg_row(REG_STRETCH_ENABLE, 8'd0));
    plan.push_back(item_row(CmdMeasure, 8'd77, 1'b1, 1'b0, 8'd0));
    plan.push_back(item_row(CmdMap, 8'd1, 1'b0, 1'b1, 8'd1));
    plan.push_back(cfg_row(REG_STRETCH_ENABLE, 8'd1));
    plan.push_back(item_row(CmdMap, 8'd77, 1'b0, 1'b1, 8'd0));
    plan.push_back(item_row(CmdMap, 8'd78, 1'b0, 1'b1, 8'd255));
    plan.push_back(item_row(CmdMeasure, 8'd10, 1'b1, 1'b0, 8'd0));
    plan.push_back(item_row(CmdMeasure, 8'd200, 1'b0, 1'b0, 8'd0));
    plan.push_back(item_row(CmdMeasure, 8'd50, 1'b0, 1'b0, 8'd0));
    plan.push_back(item_row(CmdMap, 8'd10, 1'b0, 1'b1, 8'd0));
    plan.push_back(item_row(CmdMap, 8'd200, 1'b0, 1'b1, 8'd255));
    plan.push_back(item_row(CmdMap, 8'd5, 1'b0, 1'b1, 8'd0));
    plan.push_back(item_row(CmdMap, 8'd105, 1'b0, 1'b0, 8'd0));
    plan.push_back(item_row(CmdMap, 8'd250, 1'b1, 1'b1, 8'd255));
    plan.push_back(cfg_row(REG_ISO_CUTOFF, 8'd50));
    plan.push_back(item_row(CmdMeasure, 8'd20, 1'b1, 1'b0, 8'd0));
    plan.push_back(item_row(CmdMeasure, 8'd255, 1'b0, 1'b0, 8'd0));
    plan.push_back(item_row(CmdMap, 8'd49, 1'b0, 1'b1, 8'd0));
    plan.push_back(item_row(CmdMap, 8'd50, 1'b0, 1'b0, 8'd0));
    plan.push_back(cfg_row(REG_STRETCH_ENABLE, 8'd0));
    plan.push_back(cfg_row(REG_ISO_CUTOFF, 8'd0));
    plan.push_back(cfg_row(REG_WINDOW_LOW, 8'd255));
    plan.push_back(cfg_row(REG_WINDOW_HIGH, 8'd0));
    plan.push_back(item_row(CmdMap, 8'd255, 1'b0, 1'b1, 8'd0));
    plan.push_back(item_row(CmdMap, 8'd254, 1'b0, 1'b1, 8'd0));
    plan.push_back(cfg_row(REG_WINDOW_LOW, 8'd100));
    plan.push_back(cfg_row(REG_WINDOW_HIGH, 8'd50));
    plan.push_back(item_row(CmdMap, 8'd101, 1'b0, 1'b1, 8'd255));
    plan.push_back(cfg_row(REG_WINDOW_LOW, 8'd0));
    plan.push_back(cfg_row(REG_WINDOW_HIGH, 8'd2));
    plan.push_back(item_row(CmdMap, 8'd1, 1'b0, 1'b0, 8'd0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].reg_id, plan[i].value);
      end else begin
        send_word(plan[i].cmd, plan[i].pixel, plan[i].first, plan[i].known, plan[i].grey);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(REG_STRETCH_ENABLE, 8'd1);
          write_reg(REG_ISO_CUTOFF, 8'd0);
        end
        1: begin
          write_reg(REG_STRETCH_ENABLE, 8'd0);
          write_reg(REG_WINDOW_LOW, 8'd0);
          write_reg(REG_WINDOW_HIGH, 8'd255);
          write_reg(REG_ISO_CUTOFF, 8'($urandom_range(1, 60)));
        end
        2: begin
          write_reg(REG_STRETCH_ENABLE, 8'd1);
          write_reg(REG_ISO_CUTOFF, 8'd255);
        end
        3: begin
          write_reg(REG_STRETCH_ENABLE, 8'd0);
          write_reg(REG_ISO_CUTOFF, 8'd0);
          write_reg(REG_WINDOW_LOW, 8'($urandom_range(255)));
          write_reg(REG_WINDOW_HIGH, 8'($urandom_range(255)));
        end
        4: begin
          write_reg(REG_STRETCH_ENABLE, 8'd1);
          write_reg(REG_ISO_CUTOFF, 8'($urandom_range(100)));
        end
        5: begin
          write_reg(REG_STRETCH_ENABLE, 8'd0);
          write_reg(REG_WINDOW_LOW, 8'd255);
          write_reg(REG_WINDOW_HIGH, 8'd255);
          write_reg(REG_ISO_CUTOFF, 8'($urandom_range(255)));
        end
        6: begin
          write_reg(REG_STRETCH_ENABLE, 8'd1);
          write_reg(REG_ISO_CUTOFF, 8'd0);
        end
        default: begin
          write_reg(REG_STRETCH_ENABLE, 8'd0);
          write_reg(REG_WINDOW_LOW, 8'($urandom_range(64)));
          write_reg(REG_WINDOW_HIGH, 8'($urandom_range(192, 255)));
        end
      endcase
      idle_on = (ph != 3);
      if (ph == 4) stall_req = 1'b1;
      sent = 0;
      while (sent < PhaseWords) begin
        if (stretch_q && $urandom_range(99) < 80) begin
          n = $urandom_range(10);
          m = $urandom_range(1, 10);
          send_word(CmdMeasure, any_pixel(), 1'b1, 1'b0, PixMin);
          repeat (n) send_word(CmdMeasure, any_pixel(), 1'b0, 1'b0, PixMin);
          repeat (m) send_word(CmdMap, any_pixel(), 1'($urandom_range(1)), 1'b0, PixMin);
          sent += 1 + n + m;
        end else begin
          c = stretch_q ? 1'($urandom_range(1)) : ($urandom_range(99) < 85);
          send_word(c, any_pixel(), 1'($urandom_range(1)), 1'b0, PixMin);
          sent++;
        end
      end
    end

    settle();
    if (fail_cnt == 0) begin
      $display("tile_intensity_window_stretch_top verification clean");
    end else begin
      $display("tile_intensity_window_stretch_top verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tiws_pkg.sv
hdl/tiws_if.sv
hdl/tiws_div.sv
hdl/tile_intensity_window_stretch_top.sv
tb/tb_tile_intensity_window_stretch_top.sv
